>>> rtl/stbs_pkg.sv
// stbs_pkg: shared types and constants for the sorted table binary search core.
// No dependencies; every other file in rtl/ uses this package.
`timescale 1ns / 1ps

package stbs_pkg;

  localparam int TABLE_DEPTH_DEFAULT = 256;
  localparam int KEY_W               = 32;
  localparam int INDEX_W             = 8;
  localparam int COUNT_W             = 9;

  // command queue between front and back
  localparam int QUEUE_AW    = 1;
  localparam int QUEUE_DEPTH = 2 ** QUEUE_AW;

  typedef enum logic {
    REQ_LOAD   = 1'b0,
    REQ_SEARCH = 1'b1
  } req_type_t;

  typedef enum logic {
    ST_IDLE,
    ST_SEARCH
  } back_state_t;

  // classified command: key holds the load key or the search key
  typedef struct packed {
    logic                     is_search;
    logic [INDEX_W-1:0]       index;
    logic [KEY_W-1:0]         key;
  } cmd_t;

endpackage

>>> rtl/stbs_ifs.sv
// Handshake channels of the sorted table binary search core: request, response, config.
// Depends on stbs_pkg for field widths.
`timescale 1ns / 1ps

interface stbs_req_if;
  logic                              valid;
  logic                              ready;
  logic                              req_type;
  logic [stbs_pkg::INDEX_W-1:0]      entry_index;
  logic signed [stbs_pkg::KEY_W-1:0] entry_key;
  logic signed [stbs_pkg::KEY_W-1:0] search_key;

  modport source (output valid, req_type, entry_index, entry_key, search_key, input ready);
  modport sink   (input valid, req_type, entry_index, entry_key, search_key, output ready);
endinterface

interface stbs_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         found;
  logic [stbs_pkg::INDEX_W-1:0] match_index;

  modport source (output valid, found, match_index, input ready);
  modport sink   (input valid, found, match_index, output ready);
endinterface

interface stbs_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [stbs_pkg::COUNT_W-1:0] table_count;

  modport source (output valid, table_count, input ready);
  modport sink   (input valid, table_count, output ready);
endinterface

>>> rtl/sorted_table_binary_search_core.sv
// Sorted key table with binary search: a load beat writes one key, a search beat runs one
// lookup over the first table_count entries. A search probes floor(log2(n))+1 entries at
// most (n = table_count clamped to TABLE_DEPTH) and the engine does one probe per cycle
// against the single read port of the key memory, so it takes no new beat while a search
// runs, and a load is written as it is taken from the queue. Beats pass
// a front end and a two-deep command queue first, so requests keep flowing while the
// engine works or a response waits. The key memory has no reset; only written entries may
// be searched. Write table_count only while the block is idle.
// Depends on stbs_pkg, stbs_ifs, stbs_front, stbs_queue and stbs_back.
`timescale 1ns / 1ps

module sorted_table_binary_search_core #(
  parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  stbs_req_if.sink   req,
  stbs_rsp_if.source rsp,
  stbs_cfg_if.sink   cfg
);

  localparam int IW = $clog2(TABLE_DEPTH);

  logic           push_valid;
  logic           push_ready;
  stbs_pkg::cmd_t push_data;
  logic           pop_valid;
  logic           pop_ready;
  stbs_pkg::cmd_t pop_data;
  logic [IW:0]    entry_count;

  stbs_front #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .cfg         (cfg),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_data   (push_data),
    .entry_count (entry_count)
  );

  stbs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  stbs_back #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .pop_data    (pop_data),
    .entry_count (entry_count),
    .rsp         (rsp)
  );

endmodule

>>> rtl/stbs_front.sv
// Front end: takes request beats, classifies loads and searches, drops loads past the table,
// and holds the clamped entry count. Depends on stbs_pkg and stbs_ifs.
`timescale 1ns / 1ps

module stbs_front #(
  parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEFAULT,
  localparam int IW = $clog2(TABLE_DEPTH)
) (
  input  logic           clk,
  input  logic           rst,
  stbs_req_if.sink       req,
  stbs_cfg_if.sink       cfg,
  output logic           push_valid,
  input  logic           push_ready,
  output stbs_pkg::cmd_t push_data,
  output logic [IW:0]    entry_count
);

  logic is_search;
  logic in_range;

  assign is_search = (req.req_type == stbs_pkg::REQ_SEARCH);
  assign in_range  = int'(req.entry_index) < TABLE_DEPTH;

  // an out-of-range load is taken and dropped
  assign req.ready  = push_ready;
  assign push_valid = req.valid && (is_search || in_range);

  always_comb begin
    push_data.is_search = is_search;
    push_data.index     = req.entry_index;
    push_data.key       = is_search ? req.search_key : req.entry_key;
  end

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cfg.valid) begin
      if (int'(cfg.table_count) > TABLE_DEPTH) begin
        entry_count <= (IW+1)'(TABLE_DEPTH);
      end else begin
        entry_count <= (IW+1)'(cfg.table_count);
      end
    end
  end

endmodule

>>> rtl/stbs_queue.sv
// Short command queue between the front end and the search engine.
// Depends on stbs_pkg for cmd_t and the queue depth.
`timescale 1ns / 1ps

module stbs_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  stbs_pkg::cmd_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output stbs_pkg::cmd_t pop_data
);

  stbs_pkg::cmd_t                  slots [stbs_pkg::QUEUE_DEPTH];
  logic [stbs_pkg::QUEUE_AW-1:0]   wr_ptr;
  logic [stbs_pkg::QUEUE_AW-1:0]   rd_ptr;
  logic [stbs_pkg::QUEUE_AW:0]     fill;
  logic                            do_push;
  logic                            do_pop;

  assign push_ready = (fill != (stbs_pkg::QUEUE_AW+1)'(stbs_pkg::QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

>>> rtl/stbs_back.sv
// Back end: key memory and the binary search engine, one probe per cycle, plus the
// response register. Depends on stbs_pkg and stbs_ifs.
`timescale 1ns / 1ps

module stbs_back #(
  parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEFAULT,
  localparam int IW = $clog2(TABLE_DEPTH),
  localparam int CW = IW + 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           pop_valid,
  output logic           pop_ready,
  input  stbs_pkg::cmd_t pop_data,
  input  logic [IW:0]    entry_count,
  stbs_rsp_if.source     rsp
);

  localparam logic signed [CW-1:0] ONE = CW'(1);

  logic [stbs_pkg::KEY_W-1:0] mem [TABLE_DEPTH];
  logic [stbs_pkg::KEY_W-1:0] rdata;
  logic [IW-1:0]              raddr;
  logic                       we;

  stbs_pkg::back_state_t      state, state_next;
  logic signed [CW-1:0]       low, low_next;
  logic signed [CW-1:0]       high, high_next;
  logic [IW-1:0]              mid, mid_next;
  logic [stbs_pkg::KEY_W-1:0] key, key_next;
  logic                       rsp_valid, rsp_valid_next;
  logic                       found, found_next;
  logic [stbs_pkg::INDEX_W-1:0] match_index, match_index_next;

  logic                       slot_free;
  logic [IW:0]                count_m1;
  logic signed [CW-1:0]       mid_ext;
  logic signed [CW-1:0]       low_step;
  logic signed [CW-1:0]       high_step;
  logic [CW-1:0]              span_sum;
  logic                       hit;

  assign slot_free = !rsp_valid || rsp.ready;
  assign count_m1  = entry_count - (IW+1)'(1);
  assign mid_ext   = $signed({2'b00, mid});
  assign hit       = ($signed(rdata) == $signed(key));

  always_comb begin
    if ($signed(key) > $signed(rdata)) begin
      low_step  = mid_ext + ONE;
      high_step = high;
    end else begin
      low_step  = low;
      high_step = mid_ext - ONE;
    end
  end

  assign span_sum = low_step + high_step;

  always_comb begin
    state_next       = state;
    low_next         = low;
    high_next        = high;
    mid_next         = mid;
    key_next         = key;
    rsp_valid_next   = rsp_valid && !rsp.ready;
    found_next       = found;
    match_index_next = match_index;
    pop_ready        = 1'b0;
    we               = 1'b0;
    raddr            = mid;

    unique case (state)
      stbs_pkg::ST_IDLE: begin
        // a search only starts once the response slot is free, so it stays free
        pop_ready = !pop_data.is_search || slot_free;
        if (pop_valid && pop_ready) begin
          if (!pop_data.is_search) begin
            we = 1'b1;
          end else if (entry_count == '0) begin
            rsp_valid_next   = 1'b1;
            found_next       = 1'b0;
            match_index_next = '0;
          end else begin
            key_next   = pop_data.key;
            low_next   = '0;
            high_next  = $signed({1'b0, count_m1});
            mid_next   = count_m1[IW:1];
            raddr      = count_m1[IW:1];
            state_next = stbs_pkg::ST_SEARCH;
          end
        end
      end
      stbs_pkg::ST_SEARCH: begin
        if (hit) begin
          rsp_valid_next   = 1'b1;
          found_next       = 1'b1;
          match_index_next = stbs_pkg::INDEX_W'(mid);
          state_next       = stbs_pkg::ST_IDLE;
        end else if (low_step > high_step) begin
          rsp_valid_next   = 1'b1;
          found_next       = 1'b0;
          match_index_next = '0;
          state_next       = stbs_pkg::ST_IDLE;
        end else begin
          low_next  = low_step;
          high_next = high_step;
          mid_next  = span_sum[IW:1];
          raddr     = span_sum[IW:1];
        end
      end
      default: begin
        state_next = stbs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[IW'(pop_data.index)] <= pop_data.key;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= stbs_pkg::ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    low         <= low_next;
    high        <= high_next;
    mid         <= mid_next;
    key         <= key_next;
    found       <= found_next;
    match_index <= match_index_next;
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.found       = found;
  assign rsp.match_index = match_index;

endmodule

>>> rtl/stbs_checker.sv
// Port-level checks for the sorted table binary search core, bound to the top level.
// Depends on stbs_pkg for field widths.
`timescale 1ns / 1ps

module stbs_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input logic                         rsp_found,
  input logic [stbs_pkg::INDEX_W-1:0] rsp_match_index
);

  // no stale response survives reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid right after reset");

  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response dropped while stalled");

  a_payload_holds: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(rsp_found) && $stable(rsp_match_index))
    else $error("response payload changed while stalled");

  // a miss reports index zero
  a_miss_index: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_found |-> rsp_match_index == '0)
    else $error("miss with nonzero match index");

endmodule

bind sorted_table_binary_search_core stbs_checker u_stbs_checker (
  .clk             (clk),
  .rst             (rst),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_found       (rsp.found),
  .rsp_match_index (rsp.match_index)
);

>>> test/testbench.sv
// Testbench for sorted_table_binary_search_core: loads sorted key tables and checks every
// search beat against an in-order lookup predictor. Depends on rtl/stbs_pkg and rtl/stbs_ifs.
`timescale 1ns / 1ps

typedef struct packed {
  logic       found;
  logic [7:0] match_index;
} lookup_result_t;

// Shadow of the key table and the count register, plus the searches still owed a response.
class key_table_tracker;
  logic signed [31:0] keys [stbs_pkg::TABLE_DEPTH_DEFAULT];
  bit                 written [stbs_pkg::TABLE_DEPTH_DEFAULT];
  int                 count_reg;
  lookup_result_t     lookups_due[$];
  int                 mismatches;

  function void set_count(input int n);
    count_reg = n;
  endfunction

  function int pending();
    return lookups_due.size();
  endfunction

  function bit all_written(input int m);
    for (int i = 0; i < m; i++) begin
      if (!written[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Same midpoint walk as the hardware; the first probe that matches wins.
  function lookup_result_t find_key(input logic signed [31:0] skey);
    lookup_result_t r;
    int lo, hi, mid;
    bit done;
    r.found = 1'b0;
    r.match_index = '0;
    lo = 0;
    hi = ((count_reg > stbs_pkg::TABLE_DEPTH_DEFAULT) ?
          stbs_pkg::TABLE_DEPTH_DEFAULT : count_reg) - 1;
    done = 1'b0;
    while (!done && lo <= hi) begin
      mid = (lo + hi) / 2;
      if (keys[mid] == skey) begin
        r.found = 1'b1;
        r.match_index = 8'(mid);
        done = 1'b1;
      end else if (skey > keys[mid]) begin
        lo = mid + 1;
      end else begin
        hi = mid - 1;
      end
    end
    return r;
  endfunction

  function void note_request(input stbs_pkg::req_type_t kind, input logic [7:0] slot,
                             input logic signed [31:0] ekey, input logic signed [31:0] skey);
    if (kind == stbs_pkg::REQ_LOAD) begin
      keys[slot] = ekey;
      written[slot] = 1'b1;
    end else begin
      lookups_due.push_back(find_key(skey));
    end
  endfunction

  function void check_result(input logic found, input logic [7:0] match_index);
    lookup_result_t exp;
    if (lookups_due.size() == 0) begin
      $error("response beat with no search pending");
      mismatches++;
      return;
    end
    exp = lookups_due.pop_front();
    if (found !== exp.found) begin
      $error("found: expected %0d, got %0d", exp.found, found);
      mismatches++;
    end
    if (match_index !== exp.match_index) begin
      $error("match_index: expected %0d, got %0d", exp.match_index, match_index);
      mismatches++;
    end
  endfunction
endclass

module testbench;

  localparam int     DEPTH         = stbs_pkg::TABLE_DEPTH_DEFAULT;
  localparam int     SETTLE_CYCLES = 24;
  localparam int     ITEM_TARGET   = 950;
  localparam longint KEY_MAX       = 64'sd2147483647;
  localparam longint KEY_MIN       = -KEY_MAX - 1;

  typedef enum {RX_STREAM, RX_COIN, RX_LONG_STALL} rx_mode_t;

  logic clk = 1'b0;
  logic rst;

  stbs_req_if req_bus ();
  stbs_rsp_if rsp_bus ();
  stbs_cfg_if cfg_bus ();

  key_table_tracker tracker;
  int burst_left;
  int items_sent;

  sorted_table_binary_search_core u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .rsp (rsp_bus),
    .cfg (cfg_bus)
  );

  always #1 clk = ~clk;

  initial begin
    #1_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Sender: bursts of random length separated by random gaps (sometimes none).
  task automatic send_beat(input stbs_pkg::req_type_t kind, input logic [7:0] slot,
                           input logic signed [31:0] ekey, input logic signed [31:0] skey);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        req_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req_bus.valid       <= 1'b1;
    req_bus.req_type    <= kind;
    req_bus.entry_index <= slot;
    req_bus.entry_key   <= ekey;
    req_bus.search_key  <= skey;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    tracker.note_request(kind, slot, ekey, skey);
    items_sent++;
  endtask

  // Unused fields carry random noise.
  task automatic send_load(input logic [7:0] slot, input logic signed [31:0] ekey);
    send_beat(stbs_pkg::REQ_LOAD, slot, ekey, $urandom);
  endtask

  task automatic send_search(input logic signed [31:0] skey);
    send_beat(stbs_pkg::REQ_SEARCH, 8'($urandom), $urandom, skey);
  endtask

  // Hold off until every search has answered, then let trailing loads retire.
  task automatic drain();
    req_bus.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_count(input logic [8:0] n);
    cfg_bus.valid       <= 1'b1;
    cfg_bus.table_count <= n;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    cfg_bus.valid <= 1'b0;
    tracker.set_count(n);
  endtask

  // Ascending keys in slots 0..n-1, with duplicates; sometimes pinned to both extremes.
  task automatic load_sorted(input int n);
    longint k, room, step;
    bit edges;
    edges = ($urandom_range(0, 2) == 0);
    k = edges ? KEY_MIN : KEY_MIN + longint'($urandom >> 1);
    for (int i = 0; i < n; i++) begin
      if (edges && n > 1 && i == n - 1) k = KEY_MAX;
      send_load(8'(i), 32'(k));
      room = (KEY_MAX - k) / (n - i);
      case ($urandom_range(0, 5))
        0: step = 0;
        1: step = 1;
        default: begin
          step = (room > 0) ? longint'({$urandom, $urandom} >> 1) % (2 * room + 1) : 0;
        end
      endcase
      k = (KEY_MAX - k < step) ? KEY_MAX : k + step;
    end
  endtask

  function automatic logic signed [31:0] pick_search_key(input int m);
    logic signed [31:0] k;
    int slot;
    slot = (m > 0) ? $urandom_range(0, m - 1) : 0;
    case ($urandom_range(0, 9))
      0: k = 32'(KEY_MIN);
      1: k = 32'(KEY_MAX);
      2, 3: k = $urandom;
      4: k = (m > 0) ? tracker.keys[slot] + 1 : $urandom;
      5: k = (m > 0) ? tracker.keys[slot] - 1 : $urandom;
      default: k = (m > 0) ? tracker.keys[slot] : $urandom;
    endcase
    return k;
  endfunction

  task automatic run_phase(input int count);
    int m, searches;
    drain();
    write_count(9'(count));
    m = (count > DEPTH) ? DEPTH : count;
    // a big table already fully loaded may be searched as it stands
    if (m <= 64 || !tracker.all_written(m) || $urandom_range(0, 1) == 0) load_sorted(m);
    searches = $urandom_range(15, 40);
    repeat (searches) begin
      if ($urandom_range(0, 9) == 0) begin
        send_load(8'($urandom), $urandom);
      end else begin
        send_search(pick_search_key(m));
      end
    end
  endtask

  // Receiver: switches between streaming, coin-flip and long-stall patterns.
  initial begin
    rx_mode_t mode;
    int span, hold;
    rsp_bus.ready = 1'b0;
    hold = 0;
    forever begin
      mode = rx_mode_t'($urandom_range(0, 2));
      span = $urandom_range(20, 120);
      repeat (span) begin
        @(posedge clk);
        case (mode)
          RX_STREAM: rsp_bus.ready <= 1'b1;
          RX_COIN: rsp_bus.ready <= 1'($urandom_range(0, 1));
          default: begin
            if (hold > 0) begin
              hold--;
              rsp_bus.ready <= 1'b0;
            end else if ($urandom_range(0, 15) == 0) begin
              hold = $urandom_range(1, 15);
              rsp_bus.ready <= 1'b0;
            end else begin
              rsp_bus.ready <= 1'b1;
            end
          end
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      tracker.check_result(rsp_bus.found, rsp_bus.match_index);
    end
  end

  initial begin
    tracker = new();
    burst_left = 0;
    items_sent = 0;
    rst = 1'b1;
    req_bus.valid = 1'b0;
    req_bus.req_type = stbs_pkg::REQ_LOAD;
    req_bus.entry_index = '0;
    req_bus.entry_key = '0;
    req_bus.search_key = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.table_count = '0;
    tracker.set_count(0);
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // empty table after reset: every search misses
    send_search(32'(KEY_MIN));
    send_search(32'(KEY_MAX));
    send_search('0);

    // single entry
    drain();
    write_count(9'd1);
    send_load(8'd0, 32'(KEY_MIN));
    send_search(32'(KEY_MIN));
    send_search(32'(KEY_MAX));
    send_search('0);

    // five entries with a duplicate, extremes at both ends, plus a load to the last slot
    drain();
    write_count(9'd5);
    send_load(8'd0, 32'(KEY_MIN));
    send_load(8'd1, -32'sd1);
    send_load(8'd2, '0);
    send_load(8'd3, '0);
    send_load(8'd4, 32'(KEY_MAX));
    send_load(8'd255, 32'(KEY_MAX));
    send_search(32'(KEY_MIN));
    send_search(-32'sd1);
    send_search('0);
    send_search(32'(KEY_MAX));
    send_search(32'sd1);
    send_search(-32'sd2);

    // full table, empty table, and counts past the table depth
    run_phase(DEPTH);
    run_phase(0);
    run_phase(511);
    run_phase(DEPTH + 1);

    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 19))
        0: run_phase(0);
        1: run_phase($urandom_range(DEPTH + 1, 511));
        2, 3: run_phase($urandom_range(100, DEPTH));
        default: run_phase($urandom_range(1, 40));
      endcase
    end

    drain();
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
